// ===== sv/etu_pkg.sv =====
// ----------------------------------------------------------------------------
// etu_pkg
// Shared widths, types and the fixed prime table for the totient unit.
// ----------------------------------------------------------------------------
package etu_pkg;

   localparam int N_W         = 20;
   localparam int TDATA_W     = ((N_W + 7) / 8) * 8;
   localparam int PRIME_LIMIT = 1000;
   localparam int PRIME_COUNT = 168;
   localparam int PRIME_W     = $clog2(PRIME_LIMIT);
   localparam int IDX_W       = $clog2(PRIME_COUNT);
   localparam int CNT_W       = $clog2(PRIME_COUNT + 1);
   localparam int DIV_CNT_W   = $clog2(N_W);

   typedef struct packed {
      logic           start;
      logic [N_W-1:0] dividend;
      logic [N_W-1:0] divisor;
   } div_ctl_type;

   typedef struct packed {
      logic           done;
      logic [N_W-1:0] quot;
      logic [N_W-1:0] rem;
   } div_sts_type;

   localparam logic [PRIME_W-1:0] PRIME_TAB [PRIME_COUNT] = '{
      10'd2,   10'd3,   10'd5,   10'd7,   10'd11,  10'd13,  10'd17,  10'd19,
      10'd23,  10'd29,  10'd31,  10'd37,  10'd41,  10'd43,  10'd47,  10'd53,
      10'd59,  10'd61,  10'd67,  10'd71,  10'd73,  10'd79,  10'd83,  10'd89,
      10'd97,  10'd101, 10'd103, 10'd107, 10'd109, 10'd113, 10'd127, 10'd131,
      10'd137, 10'd139, 10'd149, 10'd151, 10'd157, 10'd163, 10'd167, 10'd173,
      10'd179, 10'd181, 10'd191, 10'd193, 10'd197, 10'd199, 10'd211, 10'd223,
      10'd227, 10'd229, 10'd233, 10'd239, 10'd241, 10'd251, 10'd257, 10'd263,
      10'd269, 10'd271, 10'd277, 10'd281, 10'd283, 10'd293, 10'd307, 10'd311,
      10'd313, 10'd317, 10'd331, 10'd337, 10'd347, 10'd349, 10'd353, 10'd359,
      10'd367, 10'd373, 10'd379, 10'd383, 10'd389, 10'd397, 10'd401, 10'd409,
      10'd419, 10'd421, 10'd431, 10'd433, 10'd439, 10'd443, 10'd449, 10'd457,
      10'd461, 10'd463, 10'd467, 10'd479, 10'd487, 10'd491, 10'd499, 10'd503,
      10'd509, 10'd521, 10'd523, 10'd541, 10'd547, 10'd557, 10'd563, 10'd569,
      10'd571, 10'd577, 10'd587, 10'd593, 10'd599, 10'd601, 10'd607, 10'd613,
      10'd617, 10'd619, 10'd631, 10'd641, 10'd643, 10'd647, 10'd653, 10'd659,
      10'd661, 10'd673, 10'd677, 10'd683, 10'd691, 10'd701, 10'd709, 10'd719,
      10'd727, 10'd733, 10'd739, 10'd743, 10'd751, 10'd757, 10'd761, 10'd769,
      10'd773, 10'd787, 10'd797, 10'd809, 10'd811, 10'd821, 10'd823, 10'd827,
      10'd829, 10'd839, 10'd853, 10'd857, 10'd859, 10'd863, 10'd877, 10'd881,
      10'd883, 10'd887, 10'd907, 10'd911, 10'd919, 10'd929, 10'd937, 10'd941,
      10'd947, 10'd953, 10'd967, 10'd971, 10'd977, 10'd983, 10'd991, 10'd997
   };

endpackage

// ===== sv/etu_div.sv =====
// ----------------------------------------------------------------------------
// etu_div
// Restoring divider, one quotient bit per cycle, quotient and remainder out.
// ----------------------------------------------------------------------------
module etu_div (
   input  logic                 clock,
   input  logic                 reset,
   input  etu_pkg::div_ctl_type div_ctl,
   output etu_pkg::div_sts_type div_sts
);
   import etu_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [N_W-1:0]       quo_ff, quo_in;
   logic [N_W-1:0]       rem_ff, rem_in;
   logic [N_W-1:0]       dsr_ff, dsr_in;
   logic [N_W:0]         trial;
   logic [N_W:0]         diff;

   assign trial = {rem_ff, quo_ff[N_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (busy_ff) begin
         if (diff[N_W]) begin
            rem_in = trial[N_W-1:0];
            quo_in = {quo_ff[N_W-2:0], 1'b0};
         end else begin
            rem_in = diff[N_W-1:0];
            quo_in = {quo_ff[N_W-2:0], 1'b1};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(N_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (div_ctl.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = div_ctl.dividend;
         rem_in  = '0;
         dsr_in  = div_ctl.divisor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign div_sts.done = done_ff;
   assign div_sts.quot = quo_ff;
   assign div_sts.rem  = rem_ff;

endmodule

// ===== sv/euler_totient_unit.sv =====
// ----------------------------------------------------------------------------
// euler_totient_unit
// Euler totient of a 20-bit integer by trial division over the primes to 997.
// ----------------------------------------------------------------------------
// One item at a time: n is tried against the 168 table primes in order, each
// try being one pass of the shared restoring divider; each prime factor found
// adds a pass to scale the running totient and a pass that finds no further
// power, each further power of it adds one pass, and a leftover factor adds
// one more; the search stops early once the remaining cofactor reaches 1.
// req_tready is high only while no item is in work; a finished result waits
// in the output register without blocking the next item. n = 0 gives 0, and
// a cofactor left above 1 after the table is taken as a prime.
module euler_totient_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [19:0] n_value, [23:20] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [19:0] totient, [23:20] zero
);
   import etu_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_DIVM  = 3'd2;
   localparam logic [2:0] S_DIVR  = 3'd3;
   localparam logic [2:0] S_DIVX  = 3'd4;
   localparam logic [2:0] S_FINAL = 3'd5;
   localparam logic [2:0] S_DIVF  = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [N_W-1:0]   m_ff, m_in;
   logic [N_W-1:0]   r_ff, r_in;
   logic [N_W-1:0]   d_ff, d_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [N_W-1:0]   rsp_data_ff, rsp_data_in;

   div_ctl_type      div_ctl;
   div_sts_type      div_sts;
   logic [N_W-1:0]   n_value;
   logic [N_W-1:0]   prime;
   logic [N_W-1:0]   dm1;
   logic [2*N_W-1:0] prod;
   logic             req_fire;

   etu_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_ctl (div_ctl),
      .div_sts (div_sts)
   );

   assign n_value    = req_tdata[N_W-1:0];
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign prime      = N_W'(PRIME_TAB[idx_ff[IDX_W-1:0]]);
   assign dm1        = d_ff - N_W'(1);
   assign prod       = {{N_W{1'b0}}, div_sts.quot} * {{N_W{1'b0}}, dm1};

   always_comb begin
      state_in         = state_ff;
      idx_in           = idx_ff;
      m_in             = m_ff;
      r_in             = r_ff;
      d_in             = d_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_tready;
      rsp_data_in      = rsp_data_ff;
      div_ctl.start    = 1'b0;
      div_ctl.dividend = m_ff;
      div_ctl.divisor  = d_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               m_in   = n_value;
               r_in   = n_value;
               idx_in = '0;
               state_in = (n_value == '0) ? S_DONE : S_CHECK;
            end
         end
         S_CHECK: begin
            if (m_ff == N_W'(1) || idx_ff == CNT_W'(PRIME_COUNT)) begin
               state_in = S_FINAL;
            end else begin
               d_in             = prime;
               div_ctl.start    = 1'b1;
               div_ctl.dividend = m_ff;
               div_ctl.divisor  = prime;
               state_in         = S_DIVM;
            end
         end
         S_DIVM: begin
            if (div_sts.done) begin
               if (div_sts.rem == '0) begin
                  m_in             = div_sts.quot;
                  div_ctl.start    = 1'b1;
                  div_ctl.dividend = r_ff;
                  state_in         = S_DIVR;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_CHECK;
               end
            end
         end
         S_DIVR: begin
            if (div_sts.done) begin
               r_in             = prod[N_W-1:0];
               div_ctl.start    = 1'b1;
               div_ctl.dividend = m_ff;
               state_in         = S_DIVX;
            end
         end
         S_DIVX: begin
            if (div_sts.done) begin
               if (div_sts.rem == '0) begin
                  m_in             = div_sts.quot;
                  div_ctl.start    = 1'b1;
                  div_ctl.dividend = div_sts.quot;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_CHECK;
               end
            end
         end
         S_FINAL: begin
            if (m_ff > N_W'(1)) begin
               d_in             = m_ff;
               div_ctl.start    = 1'b1;
               div_ctl.dividend = r_ff;
               div_ctl.divisor  = m_ff;
               state_in         = S_DIVF;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DIVF: begin
            if (div_sts.done) begin
               r_in     = prod[N_W-1:0];
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = r_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      m_ff        <= m_in;
      r_ff        <= r_in;
      d_ff        <= d_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(TDATA_W - N_W){1'b0}}, rsp_data_ff};

endmodule

// ===== sv/etu_checker.sv =====
// ----------------------------------------------------------------------------
// etu_checker
// Port-level checks on the totient unit, bound to the top level.
// ----------------------------------------------------------------------------
module etu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [23:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // an accepted item makes the unit busy
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready stayed high after an item was accepted");

   // ready only drops because an item was taken
   a_ready_drop: assert property (@(posedge clock) disable iff (reset)
      $fell(req_tready) |-> $past(req_tvalid))
      else $error("ready dropped with no item offered");

   // a new result comes out exactly as the unit goes idle
   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> req_tready && !$past(req_tready))
      else $error("result appeared without finishing an item");

   // padding bits of the result stay zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[23:20] == 4'd0)
      else $error("result padding not zero");

endmodule

bind euler_totient_unit etu_checker u_etu_checker (.*);

// ===== verif/tb_euler_totient_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_euler_totient_unit
// Self-checking testbench for the Euler totient unit.
// ----------------------------------------------------------------------------
// A queue of n values is filled up front: a directed set (zero, one, the top
// of the 20-bit range, prime powers, primorials, primes and squares around
// the end of the prime table, composite cofactors beyond it), then random
// values mixing full-range, small, smooth and large-prime-factor numbers.
// A falling-edge driver sends them with random gaps, the result side stalls
// at random, and every accepted n is turned into an expected totient by a
// trial-division predictor and compared in order with the returned items.
// ----------------------------------------------------------------------------
module tb_euler_totient_unit;

   import etu_pkg::*;

   localparam int          CLK_HALF   = 2;
   localparam int unsigned N_MAX      = (1 << N_W) - 1;
   localparam int unsigned EXACT_SPAN = 1009 * 1009;
   localparam int          RANDOM_N   = 126;
   localparam int          DRAIN_WAIT = 200;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // [19:0] n_value, [23:20] zero
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // [19:0] totient, [23:20] zero

   logic [N_W-1:0] pending_n[$];
   logic [N_W-1:0] expected_totients[$];

   logic        req_hs;
   logic        rsp_hs;
   bit          req_quiet;
   bit          rsp_quiet;
   int unsigned req_gap;
   int unsigned rsp_stall;
   int unsigned n_sent;
   int unsigned n_checked;
   int unsigned n_beyond_exact;
   int unsigned n_failures;

   euler_totient_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial clock = 1'b0;
   always #(CLK_HALF) clock = ~clock;

   // phi(n); composite divisors never hit since their prime factors are gone
   function automatic logic [N_W-1:0] totient_of(input logic [N_W-1:0] n);
      int unsigned rest;
      int unsigned phi;
      int unsigned q;
      rest = n;
      phi  = n;
      if (n == 0) return '0;
      for (q = 2; q <= PRIME_LIMIT && rest > 1; q++) begin
         if (rest % q == 0) begin
            phi = phi / q * (q - 1);
            while (rest % q == 0) rest = rest / q;
         end
      end
      if (rest > 1) phi = phi / rest * (rest - 1);
      return phi[N_W-1:0];
   endfunction

   function automatic bit is_prime(input int unsigned v);
      int unsigned d;
      if (v < 2) return 1'b0;
      for (d = 2; d * d <= v; d++)
         if (v % d == 0) return 1'b0;
      return 1'b1;
   endfunction

   function automatic int unsigned random_prime(input int unsigned lo, input int unsigned hi);
      int unsigned v;
      v = $urandom_range(hi, lo);
      while (!is_prime(v)) v = (v >= hi) ? lo : v + 1;
      return v;
   endfunction

   function automatic logic [N_W-1:0] random_n();
      int unsigned v;
      int unsigned q;
      int unsigned k;
      v = 1;
      case ($urandom_range(5, 0))
         0: v = $urandom_range(N_MAX, 0);
         1: v = $urandom_range(3000, 1);
         2: begin
            // smooth numbers, many distinct and repeated factors
            repeat ($urandom_range(9, 1)) begin
               q = random_prime(2, ($urandom_range(1, 0) == 0) ? 50 : 997);
               if (v * q <= N_MAX) v = v * q;
            end
         end
         3: begin
            // one prime factor beyond the table
            k = $urandom_range(1000, 1);
            v = k * random_prime(1009, N_MAX / k);
         end
         4: begin
            // products of primes around the end of the table
            v = random_prime(900, 1039) * random_prime(900, 1039);
            if (v > N_MAX) v = random_prime(900, 1039) * 1009;
         end
         default: v = N_MAX - $urandom_range(4095, 0);
      endcase
      return v[N_W-1:0];
   endfunction

   function automatic int unsigned idle_cycles(input bit quiet);
      return quiet ? 0 : $urandom_range(18, 0);
   endfunction

   task automatic queue_n(input int unsigned v);
      pending_n.insert(pending_n.size(), v[N_W-1:0]);
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_gap    <= idle_cycles(1'b0);
      end else if (!req_tvalid || req_hs) begin
         if (req_gap != 0) begin
            req_tvalid <= 1'b0;
            req_gap    <= req_gap - 1;
         end else if (pending_n.size() != 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= {4'b0, pending_n.pop_front()};
            if ($urandom_range(15, 0) == 0) req_quiet <= !req_quiet;
            req_gap    <= idle_cycles(req_quiet);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall  <= idle_cycles(1'b0);
      end else if (rsp_hs) begin
         if ($urandom_range(15, 0) == 0) rsp_quiet <= !rsp_quiet;
         rsp_stall  <= idle_cycles(rsp_quiet);
         rsp_tready <= 1'b0;
      end else if (!rsp_tready && rsp_tvalid) begin
         if (rsp_stall == 0) rsp_tready <= 1'b1;
         else rsp_stall <= rsp_stall - 1;
      end
   end

   // monitor
   always @(posedge clock) begin
      logic [N_W-1:0] want;
      req_hs <= !reset && req_tvalid && req_tready;
      rsp_hs <= !reset && rsp_tvalid && rsp_tready;
      if (!reset && req_tvalid && req_tready) begin
         expected_totients.insert(expected_totients.size(),
                                  totient_of(req_tdata[N_W-1:0]));
         n_sent++;
         if (req_tdata[N_W-1:0] >= EXACT_SPAN) n_beyond_exact++;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_totients.size() == 0) begin
            $error("unexpected item: totient actual %0d", rsp_tdata[N_W-1:0]);
            n_failures++;
         end else begin
            want = expected_totients.pop_front();
            n_checked++;
            if (rsp_tdata[N_W-1:0] !== want) begin
               $error("totient mismatch: expected %0d actual %0d", want,
                      rsp_tdata[N_W-1:0]);
               n_failures++;
            end
         end
      end
   end

   initial begin
      req_quiet      = 1'b0;
      rsp_quiet      = 1'b0;
      req_hs         = 1'b0;
      rsp_hs         = 1'b0;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      rsp_tready     = 1'b0;
      req_gap        = 0;
      rsp_stall      = 0;
      n_sent         = 0;
      n_checked      = 0;
      n_beyond_exact = 0;
      n_failures     = 0;
      reset          = 1'b1;

      // directed values
      queue_n(0);
      queue_n(1);
      queue_n(2);
      queue_n(3);
      queue_n(4);
      queue_n(6);
      queue_n(997);
      queue_n(1000);
      queue_n(1009);
      queue_n(2018);
      queue_n(30030);
      queue_n(510510);
      queue_n(720720);
      queue_n(524288);
      queue_n(531441);
      queue_n(994009);
      queue_n(988027);
      queue_n(999983);
      queue_n(1000000);
      queue_n(1018081);
      queue_n(1022117);
      queue_n(1046429);
      queue_n(N_MAX);
      queue_n(N_MAX - 1);
      repeat (RANDOM_N) queue_n(random_n());

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_n.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_totients.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("sent %0d values of n (%0d at or above 1009 squared), checked %0d totients",
               n_sent, n_beyond_exact, n_checked);
      if (n_failures == 0) begin
         $display("** euler_totient_unit: PASSED **");
      end else begin
         $display("** euler_totient_unit: FAILED **");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("timeout with %0d totients outstanding", expected_totients.size());
      $display("** euler_totient_unit: FAILED **");
      $finish;
   end

endmodule
